// ===== rtl/prlt_pkg.sv =====
// ----------------------------------------------------------------------------
// prlt_pkg
// Shared types and constants for the periodic rate limit timer.
// ----------------------------------------------------------------------------
package prlt_pkg;

   localparam int unsigned INTERVAL_W = 18;
   localparam int unsigned NOW_W      = 32;
   localparam int unsigned WAIT_W     = 14;
   localparam int unsigned CMD_W      = 2;
   localparam int unsigned MS_W       = NOW_W + 2;

   localparam logic [CMD_W-1:0]  CMD_POLL    = 2'd0;
   localparam logic [CMD_W-1:0]  CMD_ENABLE  = 2'd1;
   localparam logic [CMD_W-1:0]  CMD_DISABLE = 2'd2;

   localparam logic [WAIT_W-1:0] DISABLED_WAIT = 14'd10000;
   localparam logic [WAIT_W-1:0] MIN_WAIT      = 14'd1;
   localparam logic [WAIT_W-1:0] NO_WAIT       = 14'd0;

   typedef enum logic [2:0] {
      STATE_IDLE,
      STATE_CHECK,
      STATE_DIVIDE,
      STATE_WAIT,
      STATE_RESPOND
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rem_status_type;

endpackage

// ===== rtl/prlt_rem.sv =====
// ----------------------------------------------------------------------------
// prlt_rem
// Radix-2 restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module prlt_rem
   import prlt_pkg::*;
#(
   parameter int unsigned DIVIDEND_W = 41
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [INTERVAL_W-1:0] divisor,
   output rem_status_type        status,
   output logic [INTERVAL_W-1:0] remainder
);

   localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] shift_ff, shift_in;
   logic [INTERVAL_W-1:0] rem_ff, rem_in;
   logic [INTERVAL_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  done_ff, done_in;
   logic [INTERVAL_W:0]   trial;
   logic [INTERVAL_W:0]   trial_sub;

   assign trial     = {rem_ff, shift_ff[DIVIDEND_W-1]};
   assign trial_sub = trial - {1'b0, div_ff};

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
         count_in = CNT_W'(DIVIDEND_W);
      end else if (count_ff != '0) begin
         shift_in = {shift_ff[DIVIDEND_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial_sub[INTERVAL_W-1:0];
         end else begin
            rem_in = trial[INTERVAL_W-1:0];
         end
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign status.busy = (count_ff != '0);
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

// ===== rtl/periodic_rate_limit_timer_top.sv =====
// ----------------------------------------------------------------------------
// periodic_rate_limit_timer_top
// Periodic deadline timer with catch-up for rate-limited event firing.
// An enable runs the remainder unit, a due poll with catch-up runs it and then
//   computes the wait, a running poll without catch-up only computes the wait,
//   and other transactions respond directly. One transaction at a time; the
//   bit-serial remainder unit takes one dividend bit per cycle.
// Reset: synchronous; timer disabled, deadline zero, interval to its default.
// ----------------------------------------------------------------------------
module periodic_rate_limit_timer_top
   import prlt_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [NOW_W-1:0]      req_now_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_fire,
   output logic [WAIT_W-1:0]     rsp_wait_ms,
   output logic                  rsp_is_enabled,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [INTERVAL_W-1:0] csr_interval
);

   localparam int unsigned TIME_W = NOW_W + FRAC_BITS;
   localparam int unsigned DL_W   = NOW_W + 1 + FRAC_BITS;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET =
      INTERVAL_W'(((64'd1 << FRAC_BITS) * 64'd1000) / 64'd60);
   localparam logic [DL_W-1:0] FRAC_MASK = DL_W'((64'd1 << FRAC_BITS) - 64'd1);

   state_type             state_ff, state_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [TIME_W-1:0]     cur_ff, cur_in;
   logic [DL_W-1:0]       deadline_ff, deadline_in;
   logic                  running_ff, running_in;
   logic [INTERVAL_W-1:0] interval_ff;
   logic                  fire_ff, fire_in;
   logic [WAIT_W-1:0]     wait_ff, wait_in;

   logic [INTERVAL_W-1:0] iv_eff;
   logic [DL_W-1:0]       cur_ext;
   logic                  due;
   logic                  rem_start;
   logic [DL_W-1:0]       rem_dividend;
   rem_status_type        rem_status;
   logic [INTERVAL_W-1:0] rem_value;
   logic [DL_W-1:0]       diff;
   logic [MS_W-1:0]       ms_sum;

   assign iv_eff  = (interval_ff == '0) ? INTERVAL_W'(1) : interval_ff;
   assign cur_ext = DL_W'(cur_ff);
   assign due     = (deadline_ff <= cur_ext);
   assign diff    = deadline_ff - cur_ext;
   assign ms_sum  = MS_W'(diff >> FRAC_BITS) + MS_W'(|(diff & FRAC_MASK));

   prlt_rem #(
      .DIVIDEND_W (DL_W)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_dividend),
      .divisor   (iv_eff),
      .status    (rem_status),
      .remainder (rem_value)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         STATE_IDLE: begin
            if (req_valid) state_in = STATE_CHECK;
         end
         STATE_CHECK: begin
            case (cmd_ff)
               CMD_ENABLE: state_in = STATE_DIVIDE;
               CMD_POLL: begin
                  if (!running_ff)   state_in = STATE_RESPOND;
                  else if (due)      state_in = STATE_DIVIDE;
                  else               state_in = STATE_WAIT;
               end
               default:    state_in = STATE_RESPOND;
            endcase
         end
         STATE_DIVIDE: begin
            if (rem_status.done) begin
               state_in = (cmd_ff == CMD_ENABLE) ? STATE_RESPOND : STATE_WAIT;
            end
         end
         STATE_WAIT:    state_in = STATE_RESPOND;
         STATE_RESPOND: begin
            if (rsp_ready) state_in = STATE_IDLE;
         end
         default:       state_in = STATE_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      rem_start    = 1'b0;
      rem_dividend = cur_ext + DL_W'(1);
      cmd_in       = cmd_ff;
      cur_in       = cur_ff;
      deadline_in  = deadline_ff;
      running_in   = running_ff;
      fire_in      = fire_ff;
      wait_in      = wait_ff;
      case (state_ff)
         STATE_IDLE: begin
            req_ready = 1'b1;
            cmd_in    = req_cmd;
            cur_in    = TIME_W'(req_now_ms) << FRAC_BITS;
         end
         STATE_CHECK: begin
            fire_in = 1'b0;
            wait_in = NO_WAIT;
            case (cmd_ff)
               CMD_ENABLE: begin
                  running_in = 1'b1;
                  rem_start  = 1'b1;
               end
               CMD_DISABLE: running_in = 1'b0;
               CMD_POLL: begin
                  if (!running_ff) begin
                     wait_in = DISABLED_WAIT;
                  end else if (due) begin
                     fire_in      = 1'b1;
                     rem_start    = 1'b1;
                     rem_dividend = cur_ext - deadline_ff;
                  end
               end
               default: ;
            endcase
         end
         STATE_DIVIDE: begin
            if (rem_status.done) begin
               if (cmd_ff == CMD_ENABLE) begin
                  deadline_in = cur_ext + DL_W'(1) - DL_W'(rem_value);
               end else begin
                  deadline_in = cur_ext - DL_W'(rem_value) + DL_W'(iv_eff);
               end
            end
         end
         STATE_WAIT: begin
            if (ms_sum > MS_W'(DISABLED_WAIT)) wait_in = DISABLED_WAIT;
            else if (ms_sum == '0)             wait_in = MIN_WAIT;
            else                               wait_in = WAIT_W'(ms_sum);
         end
         STATE_RESPOND: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= STATE_IDLE;
         running_ff  <= 1'b0;
         deadline_ff <= '0;
         interval_ff <= INTERVAL_RESET;
      end else begin
         state_ff    <= state_in;
         running_ff  <= running_in;
         deadline_ff <= deadline_in;
         if (csr_valid) interval_ff <= csr_interval;
      end
      cmd_ff  <= cmd_in;
      cur_ff  <= cur_in;
      fire_ff <= fire_in;
      wait_ff <= wait_in;
   end

   assign csr_ready      = 1'b1;
   assign rsp_fire       = fire_ff;
   assign rsp_wait_ms    = wait_ff;
   assign rsp_is_enabled = running_ff;

endmodule

// ===== rtl/prlt_checker.sv =====
// ----------------------------------------------------------------------------
// prlt_checker
// Port-level checks for the periodic rate limit timer, bound to the top.
// ----------------------------------------------------------------------------
module prlt_checker
   import prlt_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_fire,
   input logic [WAIT_W-1:0] rsp_wait_ms,
   input logic              rsp_is_enabled
);

   // one transaction in flight
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response is pending");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fire |-> rsp_is_enabled && (rsp_wait_ms != NO_WAIT))
      else $error("fire without enable or with zero wait");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_wait_ms <= DISABLED_WAIT)
      else $error("wait out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fire)
         && $stable(rsp_wait_ms) && $stable(rsp_is_enabled))
      else $error("stalled response changed");

endmodule

bind periodic_rate_limit_timer_top prlt_checker u_prlt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_fire       (rsp_fire),
   .rsp_wait_ms    (rsp_wait_ms),
   .rsp_is_enabled (rsp_is_enabled)
);
